[hdl/dra_pkg.sv]
// shared types and codes for the dirty region accumulator
package dra_pkg;

   typedef enum logic [1:0] {
      KIND_INVALIDATE = 2'd0,
      KIND_GET        = 2'd1,
      KIND_RELEASE    = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_READ = 5'b00100,
      ST_ACC  = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   typedef struct packed {
      logic        [15:0] h;
      logic        [15:0] w;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } box_type;

endpackage

[hdl/dra_ram.sv]
// generic single write port ram with registered read
module dra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[hdl/dirty_region_accumulator.sv]
// Top level of the dirty region accumulator: a rectangle fifo in ram and a
// sequencer that grows the bounding box through one shared grow unit.
// A transaction is taken when start is high and busy is low; its one result is
// shown on the rsp_ ports for a single cycle while rsp_valid is high, and the
// receiver cannot stall it. Invalidate, get, a full release and an unknown kind
// pass through the exec and resp states before the next start is taken. A
// release that keeps entries rebuilds the box by reading each remaining entry
// (at most FIFO_DEPTH of them) from the ram and passing it through the grow
// unit, in a read state and then an accumulate state per entry, before the resp
// state. An invalidate into a full fifo is dropped and reported with rsp_overflow high.
module dirty_region_accumulator #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic signed [15:0] req_rect_x,
   input  logic signed [15:0] req_rect_y,
   input  logic [15:0]        req_rect_w,
   input  logic [15:0]        req_rect_h,
   output logic               rsp_valid,
   output logic               rsp_pending,
   output logic signed [15:0] rsp_box_x,
   output logic signed [15:0] rsp_box_y,
   output logic [15:0]        rsp_box_w,
   output logic [15:0]        rsp_box_h,
   output logic               rsp_overflow
);

   import dra_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   state_type         state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   box_type           rect_ff, rect_in;
   box_type           box_ff, box_in;
   logic              pending_ff, pending_in;
   logic              ovf_ff, ovf_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  marked_ff, marked_in;
   logic [PTR_W-1:0]  walk_ptr_ff, walk_ptr_in;
   logic [CNT_W-1:0]  walk_left_ff, walk_left_in;
   logic              first_ff, first_in;

   logic              fifo_full;
   logic [CNT_W-1:0]  mark_clamped;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [63:0]       rd_data;
   box_type           unit_rect;
   box_type           unit_box;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(FIFO_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(FIFO_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   // returns {low edge, saturated extent}
   function automatic logic [31:0] grow_axis(input logic signed [15:0] b_lo,
                                             input logic [15:0] b_len,
                                             input logic signed [15:0] r_lo,
                                             input logic [15:0] r_len);
      logic signed [16:0] diff;
      logic [16:0]        span;
      logic [17:0]        reach;
      logic [15:0]        lo;
      logic [15:0]        hi_len;
      logic [15:0]        lo_len;
      logic [15:0]        len;
      diff = {r_lo[15], r_lo} - {b_lo[15], b_lo};
      if (!diff[16]) begin
         lo     = b_lo;
         span   = diff;
         hi_len = r_len;
         lo_len = b_len;
      end else begin
         lo     = r_lo;
         span   = -diff;
         hi_len = b_len;
         lo_len = r_len;
      end
      reach = {1'b0, span} + {2'b00, hi_len};
      if (reach < {2'b00, lo_len}) begin
         reach = {2'b00, lo_len};
      end
      len = (reach > 18'd65535) ? 16'hFFFF : reach[15:0];
      return {lo, len};
   endfunction

   assign fifo_full    = (count_ff == CNT_W'(FIFO_DEPTH));
   assign mark_clamped = (marked_ff > count_ff) ? count_ff : marked_ff;
   assign wr_addr      = wrap_add(head_ff, count_ff);
   assign wr_en        = (state_ff == ST_EXEC) && (kind_ff == KIND_INVALIDATE) && !fifo_full;

   dra_ram #(
      .WIDTH (64),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rect_ff),
      .rd_addr (walk_ptr_ff),
      .rd_data (rd_data)
   );

   // shared grow unit
   always_comb begin
      logic [31:0] ax;
      logic [31:0] ay;
      unit_rect = (state_ff == ST_ACC) ? box_type'(rd_data) : rect_ff;
      ax = grow_axis(box_ff.x, box_ff.w, unit_rect.x, unit_rect.w);
      ay = grow_axis(box_ff.y, box_ff.h, unit_rect.y, unit_rect.h);
      unit_box.x = ax[31:16];
      unit_box.w = ax[15:0];
      unit_box.y = ay[31:16];
      unit_box.h = ay[15:0];
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rect_in      = rect_ff;
      box_in       = box_ff;
      pending_in   = pending_ff;
      ovf_in       = ovf_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      marked_in    = marked_ff;
      walk_ptr_in  = walk_ptr_ff;
      walk_left_in = walk_left_ff;
      first_in     = first_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in   = req_kind;
               rect_in.x = req_rect_x;
               rect_in.y = req_rect_y;
               rect_in.w = req_rect_w;
               rect_in.h = req_rect_h;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ovf_in   = 1'b0;
            state_in = ST_RESP;
            case (kind_ff)
               KIND_INVALIDATE: begin
                  if (fifo_full) begin
                     ovf_in = 1'b1;
                  end else begin
                     count_in   = count_ff + CNT_W'(1);
                     pending_in = 1'b1;
                     box_in     = pending_ff ? unit_box : rect_ff;
                  end
               end
               KIND_GET: begin
                  marked_in = count_ff;
               end
               KIND_RELEASE: begin
                  marked_in = '0;
                  if (count_ff == mark_clamped) begin
                     pending_in = 1'b0;
                     head_in    = '0;
                     count_in   = '0;
                  end else begin
                     head_in      = wrap_add(head_ff, mark_clamped);
                     count_in     = count_ff - mark_clamped;
                     pending_in   = 1'b1;
                     walk_ptr_in  = wrap_add(head_ff, mark_clamped);
                     walk_left_in = count_ff - mark_clamped;
                     first_in     = 1'b1;
                     state_in     = ST_READ;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_READ: begin
            walk_ptr_in = wrap_add(walk_ptr_ff, CNT_W'(1));
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            box_in       = first_ff ? box_type'(rd_data) : unit_box;
            first_in     = 1'b0;
            walk_left_in = walk_left_ff - CNT_W'(1);
            state_in     = (walk_left_ff == CNT_W'(1)) ? ST_RESP : ST_READ;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         box_ff       <= '0;
         pending_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         marked_ff    <= '0;
         walk_left_ff <= '0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         box_ff       <= box_in;
         pending_ff   <= pending_in;
         ovf_ff       <= ovf_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         marked_ff    <= marked_in;
         walk_left_ff <= walk_left_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      rect_ff     <= rect_in;
      walk_ptr_ff <= walk_ptr_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESP);
   assign rsp_pending  = pending_ff;
   assign rsp_box_x    = box_ff.x;
   assign rsp_box_y    = box_ff.y;
   assign rsp_box_w    = box_ff.w;
   assign rsp_box_h    = box_ff.h;
   assign rsp_overflow = ovf_ff;

   // fifo never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("fifo count beyond depth");

   // a get never covers more than is stored
   a_marked_bound: assert property (@(posedge clock) disable iff (reset)
      marked_ff <= count_ff)
      else $error("marked count beyond fifo count");

   // a region is outstanding exactly when entries are stored
   a_pending_count: assert property (@(posedge clock) disable iff (reset)
      pending_ff == (count_ff != '0))
      else $error("pending flag disagrees with fifo count");

   // the rebuild walk stays inside the stored entries
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_ACC) |->
         (walk_left_ff != '0 && walk_left_ff <= count_ff))
      else $error("rebuild walk out of range");

   // each result strobe is followed by idle before the next transaction is taken
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("result strobe not followed by idle");

endmodule
